// ----- sv/fct_pkg.sv -----
package fct_pkg;

    localparam int NUM_PLANES_DEF  = 6;
    localparam int COORD_WIDTH_DEF = 32;

    // Fixed widths of the item fields.
    localparam int FIELD_W = 32;
    localparam int OP_W    = 3;
    localparam int IDX_W   = 3;

    // Fraction bits of the Q16.16 values.
    localparam int FRAC_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 3'd0,
        OP_POINT  = 3'd1,
        OP_SPHERE = 3'd2,
        OP_CUBE   = 3'd3,
        OP_BOXC   = 3'd4,
        OP_BOXM   = 3'd5
    } t_op;

    // Step counter of the per-plane schedule.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_MUL_FIRST = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ACC_CLR   = 3'd2;
    localparam logic [STEP_W-1:0] STEP_D         = 3'd4;
    localparam logic [STEP_W-1:0] STEP_ACC_LAST  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_EVAL      = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LOAD_LAST = 3'd3;

    typedef struct packed {
        logic mul_en;
        logic d_term;
        logic acc_clr;
        logic acc_add;
    } t_mac_ctrl;

    typedef struct packed {
        logic neg;
        logic zero;
    } t_acc_sign;

endpackage

// ----- sv/fct_plane_mem.sv -----
module fct_plane_mem #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = 4 * fct_pkg::NUM_PLANES_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [ADDR_W-1:0]             i_waddr,
    input  logic signed [COORD_WIDTH-1:0] i_wdata,
    input  logic [ADDR_W-1:0]             i_raddr,
    output logic signed [COORD_WIDTH-1:0] o_rdata
);

    logic signed [COORD_WIDTH-1:0] r_mem [DEPTH];
    logic signed [COORD_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/fct_mac.sv -----
module fct_mac #(
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  fct_pkg::t_mac_ctrl            i_ctrl,
    input  logic signed [COORD_WIDTH-1:0] i_coef,
    input  logic signed [COORD_WIDTH:0]   i_lo,
    input  logic signed [COORD_WIDTH:0]   i_hi,
    input  logic                          i_hi_ge,
    input  logic signed [COORD_WIDTH-1:0] i_extra,
    output fct_pkg::t_acc_sign            o_sign
);

    localparam int CW     = COORD_WIDTH;
    localparam int PROD_W = 2 * CW + 1;
    localparam int ACC_W  = 2 * CW + 3;

    logic signed [CW:0]         coord;
    logic signed [CW:0]         dsum;
    logic signed [PROD_W-1:0]   mul;
    logic signed [PROD_W-1:0]   dterm;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PROD_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;

    // The corner that makes this term largest: the larger coordinate for a
    // non-negative coefficient, the smaller one otherwise.
    assign coord = ((!i_coef[CW-1]) == i_hi_ge) ? i_hi : i_lo;
    assign dsum  = {i_coef[CW-1], i_coef} + {i_extra[CW-1], i_extra};
    assign mul   = PROD_W'(i_coef) * PROD_W'(coord);
    assign dterm = PROD_W'($signed({dsum, {fct_pkg::FRAC_W{1'b0}}}));

    always_comb begin
        n_prod = r_prod;
        n_acc  = r_acc;
        if (i_ctrl.mul_en) begin
            n_prod = i_ctrl.d_term ? dterm : mul;
        end
        if (i_ctrl.acc_clr) begin
            n_acc = ACC_W'(r_prod);
        end else if (i_ctrl.acc_add) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
    end

    assign o_sign.neg  = r_acc[ACC_W-1];
    assign o_sign.zero = (r_acc == '0);

endmodule

// ----- sv/frustum_cull_tester_unit.sv -----
// View frustum culling tester over NUM_PLANES stored planes in signed Q16.16.
// Input channel: i_in_valid / o_in_stall carry one word (op, plane index and
// six values); a word is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry one word, the visible flag.
// A load word writes the four coefficients of one plane in turn and gives no
// result; a load to a plane beyond the store, and an unused op, are ignored
// and give no result. A query runs the planes in turn through one shared
// multiply-accumulate unit and one plane memory whose read and write ports
// share an address: per plane, four coefficient reads, three products and the
// offset term, then the sign test. The query stops at the first plane that
// culls. The input is stalled while the query runs; the next word may be taken
// in the cycle the result appears. The result sits in an output register; if it
// is still stalled when the next result is ready, the unit waits in its last
// step. Reset (synchronous, active low) empties the output and returns the
// sequencer to idle; the plane store is not cleared, so planes must be loaded
// before they are queried.
module frustum_cull_tester_unit #(
    parameter int NUM_PLANES  = fct_pkg::NUM_PLANES_DEF,
    parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [fct_pkg::OP_W-1:0]           i_op,
    input  logic [fct_pkg::IDX_W-1:0]          i_plane_index,
    input  logic signed [fct_pkg::FIELD_W-1:0] i_val_a,
    input  logic signed [fct_pkg::FIELD_W-1:0] i_val_b,
    input  logic signed [fct_pkg::FIELD_W-1:0] i_val_c,
    input  logic signed [fct_pkg::FIELD_W-1:0] i_val_d,
    input  logic signed [fct_pkg::FIELD_W-1:0] i_val_e,
    input  logic signed [fct_pkg::FIELD_W-1:0] i_val_f,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_visible
);

    localparam int CW      = COORD_WIDTH;
    localparam int DEPTH   = 4 * NUM_PLANES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam logic [PLANE_W-1:0] LAST_PLANE = PLANE_W'(NUM_PLANES - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_LOAD = 3'b010,
        S_RUN  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [fct_pkg::STEP_W-1:0]      r_step, n_step;
    logic [PLANE_W-1:0]              r_plane, n_plane;
    logic                            r_out_valid, n_out_valid;
    logic                            r_visible, n_visible;
    logic                            r_strict, n_strict;
    logic [2:0]                      r_hi_ge, n_hi_ge;
    logic signed [CW:0]              r_lo [3];
    logic signed [CW:0]              n_lo [3];
    logic signed [CW:0]              r_hi [3];
    logic signed [CW:0]              n_hi [3];
    logic signed [CW-1:0]            r_extra, n_extra;

    logic signed [CW-1:0]            v [6];
    logic signed [CW:0]              w [6];
    logic                            out_free;
    logic                            culled;
    logic                            mem_we;
    logic [ADDR_W-1:0]               mem_addr;
    logic signed [CW-1:0]            mem_wdata;
    logic signed [CW-1:0]            mem_rdata;
    fct_pkg::t_mac_ctrl              mac_ctrl;
    fct_pkg::t_acc_sign              acc_sign;
    logic signed [CW:0]              sel_lo;
    logic signed [CW:0]              sel_hi;
    logic                            sel_hi_ge;

    assign v[0] = $signed(i_val_a[CW-1:0]);
    assign v[1] = $signed(i_val_b[CW-1:0]);
    assign v[2] = $signed(i_val_c[CW-1:0]);
    assign v[3] = $signed(i_val_d[CW-1:0]);
    assign v[4] = $signed(i_val_e[CW-1:0]);
    assign v[5] = $signed(i_val_f[CW-1:0]);

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w[i] = {v[i][CW-1], v[i]};
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign culled   = r_strict ? acc_sign.neg : (acc_sign.neg || acc_sign.zero);

    // Both the load writes and the query reads walk the four coefficients
    // of one plane with the low step bits.
    assign mem_addr = ADDR_W'({r_plane, r_step[1:0]});
    assign mem_we   = (r_state == S_LOAD);

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    mem_wdata = r_lo[0][CW-1:0];
            2'd1:    mem_wdata = r_lo[1][CW-1:0];
            2'd2:    mem_wdata = r_lo[2][CW-1:0];
            default: mem_wdata = r_extra;
        endcase
    end

    // Coefficient k arrives from the registered memory in the step after its read.
    always_comb begin
        unique case (r_step)
            3'd2: begin
                sel_lo = r_lo[1]; sel_hi = r_hi[1]; sel_hi_ge = r_hi_ge[1];
            end
            3'd3: begin
                sel_lo = r_lo[2]; sel_hi = r_hi[2]; sel_hi_ge = r_hi_ge[2];
            end
            default: begin
                sel_lo = r_lo[0]; sel_hi = r_hi[0]; sel_hi_ge = r_hi_ge[0];
            end
        endcase
    end

    always_comb begin
        mac_ctrl.mul_en  = (r_state == S_RUN) && (r_step >= fct_pkg::STEP_MUL_FIRST)
                           && (r_step <= fct_pkg::STEP_D);
        mac_ctrl.d_term  = (r_step == fct_pkg::STEP_D);
        mac_ctrl.acc_clr = (r_state == S_RUN) && (r_step == fct_pkg::STEP_ACC_CLR);
        mac_ctrl.acc_add = (r_state == S_RUN) && (r_step > fct_pkg::STEP_ACC_CLR)
                           && (r_step <= fct_pkg::STEP_ACC_LAST);
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_plane     = r_plane;
        n_out_valid = r_out_valid;
        n_visible   = r_visible;
        n_strict    = r_strict;
        n_hi_ge     = r_hi_ge;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_extra     = r_extra;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_step  = '0;
                    n_plane = '0;
                    n_extra = '0;
                    unique case (i_op)
                        fct_pkg::OP_LOAD: begin
                            for (int i = 0; i < 3; i++) begin
                                n_lo[i] = w[i];
                            end
                            n_extra = v[3];
                            n_plane = PLANE_W'(i_plane_index);
                            if ({1'b0, i_plane_index} < 4'(NUM_PLANES)) begin
                                n_state = S_LOAD;
                            end
                        end
                        fct_pkg::OP_POINT, fct_pkg::OP_SPHERE: begin
                            for (int i = 0; i < 3; i++) begin
                                n_lo[i] = w[i];
                                n_hi[i] = w[i];
                            end
                            n_hi_ge  = 3'b111;
                            n_strict = 1'b0;
                            if (i_op == fct_pkg::OP_SPHERE) begin
                                n_extra = v[3];
                            end
                            n_state = S_RUN;
                        end
                        fct_pkg::OP_CUBE: begin
                            for (int i = 0; i < 3; i++) begin
                                n_lo[i]    = w[i] - w[3];
                                n_hi[i]    = w[i] + w[3];
                                n_hi_ge[i] = !v[3][CW-1];
                            end
                            n_strict = 1'b0;
                            n_state  = S_RUN;
                        end
                        fct_pkg::OP_BOXC: begin
                            for (int i = 0; i < 3; i++) begin
                                n_lo[i]    = w[i] - w[3+i];
                                n_hi[i]    = w[i] + w[3+i];
                                n_hi_ge[i] = !v[3+i][CW-1];
                            end
                            n_strict = 1'b1;
                            n_state  = S_RUN;
                        end
                        fct_pkg::OP_BOXM: begin
                            for (int i = 0; i < 3; i++) begin
                                n_lo[i]    = w[i];
                                n_hi[i]    = w[3+i];
                                n_hi_ge[i] = (w[3+i] >= w[i]);
                            end
                            n_strict = 1'b1;
                            n_state  = S_RUN;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                n_step = r_step + 3'd1;
                if (r_step == fct_pkg::STEP_LOAD_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                if (r_step == fct_pkg::STEP_EVAL) begin
                    if (culled || (r_plane == LAST_PLANE)) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_visible   = !culled;
                            n_state     = S_IDLE;
                        end
                    end else begin
                        n_plane = r_plane + 1'b1;
                        n_step  = '0;
                    end
                end else begin
                    n_step = r_step + 3'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_plane     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_plane     <= n_plane;
            r_out_valid <= n_out_valid;
        end
        r_visible <= n_visible;
        r_strict  <= n_strict;
        r_hi_ge   <= n_hi_ge;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_extra   <= n_extra;
    end

    fct_plane_mem #(
        .COORD_WIDTH(CW),
        .DEPTH      (DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_addr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_addr),
        .o_rdata(mem_rdata)
    );

    fct_mac #(
        .COORD_WIDTH(CW)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (mac_ctrl),
        .i_coef (mem_rdata),
        .i_lo   (sel_lo),
        .i_hi   (sel_hi),
        .i_hi_ge(sel_hi_ge),
        .i_extra(r_extra),
        .o_sign (acc_sign)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_visible   = r_visible;

    a_result_from_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_RUN && r_step == fct_pkg::STEP_EVAL))
        else $error("result raised outside the evaluation step");

    a_plane_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN || r_state == S_LOAD) |-> (r_plane <= LAST_PLANE))
        else $error("plane counter beyond the plane store");

    a_load_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_op == fct_pkg::OP_LOAD) |=> (r_state != S_RUN))
        else $error("load word started a query");

    a_wait_on_full_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == fct_pkg::STEP_EVAL && !out_free
         && (culled || r_plane == LAST_PLANE))
        |=> (r_state == S_RUN && r_step == fct_pkg::STEP_EVAL))
        else $error("result dropped while the output was stalled");

endmodule

// ----- tb/tb_frustum_cull_tester_unit.sv -----
`timescale 1ns / 1ps

module tb_frustum_cull_tester_unit;

    localparam int NUM_PLANES = fct_pkg::NUM_PLANES_DEF;
    localparam int SPAN_W     = fct_pkg::FIELD_W + 2;
    localparam int ACC_W      = 96;
    localparam int ONE        = 1 << fct_pkg::FRAC_W;
    localparam int MAX_Q      = 32'sh7FFF_FFFF;
    localparam int MIN_Q      = 32'sh8000_0000;
    localparam int HOLD_AT    = 200;
    localparam int HOLD_LEN   = 400;
    localparam int SETTLE     = 60;

    // Op codes that the block leaves unused.
    localparam logic [fct_pkg::OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [fct_pkg::OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef struct packed {
        logic [fct_pkg::OP_W-1:0]          op;
        logic [fct_pkg::IDX_W-1:0]         idx;
        logic [5:0][fct_pkg::FIELD_W-1:0]  vals;
        logic [3:0]                        gap;
        logic                              drain;
    } t_word;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic                               i_in_valid    = 1'b0;
    logic [fct_pkg::OP_W-1:0]           i_op          = '0;
    logic [fct_pkg::IDX_W-1:0]          i_plane_index = '0;
    logic signed [fct_pkg::FIELD_W-1:0] i_val_a       = '0;
    logic signed [fct_pkg::FIELD_W-1:0] i_val_b       = '0;
    logic signed [fct_pkg::FIELD_W-1:0] i_val_c       = '0;
    logic signed [fct_pkg::FIELD_W-1:0] i_val_d       = '0;
    logic signed [fct_pkg::FIELD_W-1:0] i_val_e       = '0;
    logic signed [fct_pkg::FIELD_W-1:0] i_val_f       = '0;
    logic                               i_out_stall   = 1'b0;
    logic                               o_in_stall;
    logic                               o_out_valid;
    logic                               o_visible;

    logic signed [fct_pkg::FIELD_W-1:0] plane_coef [NUM_PLANES][4];
    t_word word_q [$];
    logic  visible_q [$];
    t_word cur;
    int    gap_left  = 0;
    int    sink_wait = 0;
    int    got_cnt   = 0;
    int    hold_left = 0;
    bit    hold_armed = 1'b1;
    int    err_cnt   = 0;
    int    n_items   = 0;
    bit    calm_send  = 1'b0;
    bit    drain_next = 1'b0;

    frustum_cull_tester_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_plane_index (i_plane_index),
        .i_val_a       (i_val_a),
        .i_val_b       (i_val_b),
        .i_val_c       (i_val_c),
        .i_val_d       (i_val_d),
        .i_val_e       (i_val_e),
        .i_val_f       (i_val_f),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_visible     (o_visible)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sign of a*x + b*y + c*z + d + extra for one plane, formed exactly.
    function automatic int plane_side(input int p,
                                      input logic signed [SPAN_W-1:0] x, y, z, extra);
        logic signed [ACC_W-1:0] ka, kb, kc, kd, wx, wy, wz, we, acc;
        ka = ACC_W'(plane_coef[p][0]);
        kb = ACC_W'(plane_coef[p][1]);
        kc = ACC_W'(plane_coef[p][2]);
        kd = ACC_W'(plane_coef[p][3]);
        wx = ACC_W'(x);
        wy = ACC_W'(y);
        wz = ACC_W'(z);
        we = ACC_W'(extra);
        acc = ka * wx + kb * wy + kc * wz + ((kd + we) <<< fct_pkg::FRAC_W);
        if (acc < 0)
            return -1;
        return (acc == 0) ? 0 : 1;
    endfunction

    function automatic logic ball_in_view(input logic signed [SPAN_W-1:0] x, y, z, r);
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (plane_side(p, x, y, z, r) <= 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // A plane culls the box when every corner lies below it (or on it, if not strict).
    function automatic logic box_in_view(input logic signed [SPAN_W-1:0] lx, ly, lz,
                                         input logic signed [SPAN_W-1:0] hx, hy, hz,
                                         input bit strict);
        bit                       culled;
        int                       s;
        logic signed [SPAN_W-1:0] x, y, z;
        for (int p = 0; p < NUM_PLANES; p++) begin
            culled = 1'b1;
            for (int k = 0; k < 8; k++) begin
                x = ((k & 1) != 0) ? hx : lx;
                y = ((k & 2) != 0) ? hy : ly;
                z = ((k & 4) != 0) ? hz : lz;
                s = plane_side(p, x, y, z, '0);
                if (strict ? (s >= 0) : (s > 0))
                    culled = 1'b0;
            end
            if (culled)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void book_word(input t_word w);
        logic signed [fct_pkg::FIELD_W-1:0] v [6];
        logic signed [SPAN_W-1:0]           s [6];
        for (int k = 0; k < 6; k++) begin
            v[k] = w.vals[k];
            s[k] = SPAN_W'(v[k]);
        end
        case (w.op)
            fct_pkg::OP_LOAD: begin
                if (w.idx < NUM_PLANES) begin
                    for (int k = 0; k < 4; k++)
                        plane_coef[w.idx][k] = v[k];
                end
            end
            fct_pkg::OP_POINT:  visible_q.push_back(ball_in_view(s[0], s[1], s[2], '0));
            fct_pkg::OP_SPHERE: visible_q.push_back(ball_in_view(s[0], s[1], s[2], s[3]));
            fct_pkg::OP_CUBE: begin
                visible_q.push_back(box_in_view(
                    s[0] - s[3], s[1] - s[3], s[2] - s[3],
                    s[0] + s[3], s[1] + s[3], s[2] + s[3], 1'b0));
            end
            fct_pkg::OP_BOXC: begin
                visible_q.push_back(box_in_view(
                    s[0] - s[3], s[1] - s[4], s[2] - s[5],
                    s[0] + s[3], s[1] + s[4], s[2] + s[5], 1'b1));
            end
            fct_pkg::OP_BOXM:
                visible_q.push_back(box_in_view(s[0], s[1], s[2], s[3], s[4], s[5], 1'b1));
            default: ;
        endcase
    endfunction

    task automatic add_word(input int op, input int idx, input int a, b, c, d, e, f);
        t_word w;
        w.op      = fct_pkg::OP_W'(op);
        w.idx     = fct_pkg::IDX_W'(idx);
        w.vals[0] = a;
        w.vals[1] = b;
        w.vals[2] = c;
        w.vals[3] = d;
        w.vals[4] = e;
        w.vals[5] = f;
        w.gap     = calm_send ? 4'd0 : 4'($urandom_range(0, 15));
        w.drain   = drain_next;
        drain_next = 1'b0;
        word_q.push_back(w);
        if (!(w.op > fct_pkg::OP_BOXM || (w.op == fct_pkg::OP_LOAD && w.idx >= NUM_PLANES)))
            n_items++;
    endtask

    // Axis-aligned cube of half width reach around the origin.
    task automatic box_planes(input int reach);
        add_word(fct_pkg::OP_LOAD, 0, ONE, 0, 0, reach, 0, 0);
        add_word(fct_pkg::OP_LOAD, 1, -ONE, 0, 0, reach, 0, 0);
        add_word(fct_pkg::OP_LOAD, 2, 0, ONE, 0, reach, 0, 0);
        add_word(fct_pkg::OP_LOAD, 3, 0, -ONE, 0, reach, 0, 0);
        add_word(fct_pkg::OP_LOAD, 4, 0, 0, ONE, reach, 0, 0);
        add_word(fct_pkg::OP_LOAD, 5, 0, 0, -ONE, reach, 0, 0);
    endtask

    function automatic int coord(input int reach, input bit exact);
        if (exact)
            return (int'($urandom_range(0, 6)) - 3) * (reach / 2);
        return int'($urandom_range(0, 3 * reach)) - (3 * reach) / 2;
    endfunction

    task automatic add_query(input int reach, input bit exact);
        int op;
        int p [3];
        int s [3];
        op = int'($urandom_range(fct_pkg::OP_POINT, fct_pkg::OP_BOXM));
        for (int k = 0; k < 3; k++) begin
            p[k] = coord(reach, exact);
            s[k] = exact ? int'($urandom_range(0, 2)) * (reach / 2)
                         : int'($urandom_range(0, reach)) - reach / 8;
        end
        if (op == fct_pkg::OP_POINT)
            add_word(op, int'($urandom_range(0, 7)), p[0], p[1], p[2],
                     $urandom, $urandom, $urandom);
        else if (op == fct_pkg::OP_BOXM)
            add_word(op, int'($urandom_range(0, 7)), p[0], p[1], p[2],
                     p[0] + s[0], p[1] + s[1], p[2] + s[2]);
        else
            add_word(op, int'($urandom_range(0, 7)), p[0], p[1], p[2], s[0], s[1], s[2]);
    endtask

    always @(posedge i_clk) begin : word_source
        t_word nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (i_in_valid)
                book_word(cur);
            if (gap_left != 0) begin
                gap_left   <= gap_left - 1;
                i_in_valid <= 1'b0;
            end else if (word_q.size() != 0 && !(word_q[0].drain && visible_q.size() != 0)) begin
                nxt = word_q.pop_front();
                cur           <= nxt;
                i_op          <= nxt.op;
                i_plane_index <= nxt.idx;
                i_val_a       <= nxt.vals[0];
                i_val_b       <= nxt.vals[1];
                i_val_c       <= nxt.vals[2];
                i_val_d       <= nxt.vals[3];
                i_val_e       <= nxt.vals[4];
                i_val_f       <= nxt.vals[5];
                gap_left      <= nxt.gap;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // One long hold-off on the result side so the block backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && got_cnt == HOLD_AT) begin
            hold_armed <= 1'b0;
            hold_left  <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : result_sink
        logic want;
        int   wait_n;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            sink_wait   <= 0;
            got_cnt     <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            got_cnt     <= got_cnt + 1;
            wait_n      = (((got_cnt >> 6) % 3) == 0) ? 0 : int'($urandom_range(0, 15));
            sink_wait   <= wait_n;
            i_out_stall <= (hold_left != 0) || (wait_n != 0);
            if (visible_q.size() == 0) begin
                $display("%0t: result with none expected: expected none, got visible=%0b",
                         $time, o_visible);
                err_cnt++;
            end else begin
                want = visible_q.pop_front();
                if (o_visible !== want) begin
                    $display("%0t: visible mismatch: expected %0b, got %0b",
                             $time, want, o_visible);
                    err_cnt++;
                end
            end
        end else begin
            if (sink_wait != 0)
                sink_wait <= sink_wait - 1;
            i_out_stall <= (hold_left != 0) || (sink_wait > 1);
        end
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : run
        int  reach;
        int  kind;
        bit  exact;
        bit  drained;
        reach   = 10 * ONE;
        drained = 1'b0;

        // Directed: faces touched exactly, strict against non-strict tests,
        // swapped min/max, ignored words and full-scale values.
        box_planes(reach);
        add_word(fct_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0);
        add_word(fct_pkg::OP_POINT, 0, -reach, 0, 0, 0, 0, 0);
        add_word(fct_pkg::OP_SPHERE, 0, -reach - 2 * ONE, 0, 0, 2 * ONE, 0, 0);
        add_word(fct_pkg::OP_SPHERE, 0, -reach - 2 * ONE, 0, 0, 3 * ONE, 0, 0);
        add_word(fct_pkg::OP_CUBE, 0, -reach - ONE, 0, 0, ONE, 0, 0);
        add_word(fct_pkg::OP_BOXC, 0, -reach - ONE, 0, 0, ONE, ONE, ONE);
        add_word(fct_pkg::OP_BOXM, 0, -reach - 2 * ONE, -ONE, -ONE, -reach, ONE, ONE);
        add_word(fct_pkg::OP_BOXM, 0, -reach - 2 * ONE, -ONE, -ONE, -reach - ONE, ONE, ONE);
        add_word(fct_pkg::OP_BOXM, 0, -reach, -ONE, -ONE, -reach - 2 * ONE, ONE, ONE);
        drain_next = 1'b1;
        add_word(fct_pkg::OP_LOAD, NUM_PLANES, 0, 0, 0, 0, 0, 0);
        add_word(fct_pkg::OP_LOAD, NUM_PLANES + 1, 0, 0, 0, 0, 0, 0);
        add_word(OP_SPARE_A, 7, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q);
        add_word(OP_SPARE_B, 0, MIN_Q, MAX_Q, MIN_Q, MAX_Q, MIN_Q, MAX_Q);
        add_word(fct_pkg::OP_POINT, 0, 0, 0, 0, 0, 0, 0);
        add_word(fct_pkg::OP_POINT, 0, MAX_Q, MAX_Q, MAX_Q, 0, 0, 0);
        add_word(fct_pkg::OP_POINT, 0, MIN_Q, MIN_Q, MIN_Q, 0, 0, 0);
        add_word(fct_pkg::OP_CUBE, 0, MIN_Q, MIN_Q, MIN_Q, MAX_Q, 0, 0);
        add_word(fct_pkg::OP_LOAD, 0, MIN_Q, MIN_Q, MIN_Q, MIN_Q, 0, 0);
        add_word(fct_pkg::OP_POINT, 0, MIN_Q, MIN_Q, MIN_Q, 0, 0, 0);
        add_word(fct_pkg::OP_BOXM, 0, MIN_Q, MIN_Q, MIN_Q, MAX_Q, MAX_Q, MAX_Q);
        add_word(fct_pkg::OP_LOAD, 0, ONE, 0, 0, reach, 0, 0);

        while (n_items < 700) begin
            calm_send = ($urandom_range(0, 3) == 0);
            if (!drained && n_items >= 350) begin
                drain_next = 1'b1;
                drained    = 1'b1;
            end
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                exact = (kind < 2);
                reach = exact ? (1 << $urandom_range(16, 24))
                              : int'($urandom_range(ONE, 1 << 24));
                box_planes(reach);
                repeat (20) add_query(reach, exact);
            end else if (kind < 8) begin
                reach = $urandom_range(ONE, 1 << 24);
                for (int p = 0; p < NUM_PLANES; p++)
                    add_word(fct_pkg::OP_LOAD, p, int'($urandom_range(0, 2 * ONE)) - ONE,
                             int'($urandom_range(0, 2 * ONE)) - ONE,
                             int'($urandom_range(0, 2 * ONE)) - ONE,
                             $urandom_range(reach / 4, reach), $urandom, $urandom);
                repeat (20) add_query(reach / 4, 1'b0);
            end else if (kind == 8) begin
                repeat (15)
                    add_word(int'($urandom_range(0, 7)), int'($urandom_range(0, 7)),
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                repeat (3) begin
                    add_word(fct_pkg::OP_LOAD, NUM_PLANES + int'($urandom_range(0, 1)),
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                    add_word(int'($urandom_range(OP_SPARE_A, OP_SPARE_B)),
                             int'($urandom_range(0, 7)),
                             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (word_q.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (visible_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (err_cnt == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
